// File: sv/link_cycle_checker_unit_macros.svh
// assertion macros used by the link cycle checker datapath
// no dependencies; included by lcc_dpath, which carries the concurrent checks
`ifndef LINK_CYCLE_CHECKER_UNIT_MACROS_SVH
`define LINK_CYCLE_CHECKER_UNIT_MACROS_SVH

// same-cycle implication, disabled while reset is held
`define LCC_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while reset is held
`define LCC_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/lcc_pkg.sv
// shared types, constants and helpers for the link cycle checker
// no dependencies; imported by the controller, the datapath and the top level
`timescale 1ns / 1ps
`default_nettype none

package lcc_pkg;

  localparam int NODES  = 64;
  localparam int NODE_W = 6;

  // command codes
  typedef enum logic [1:0] {
    CMD_CLEAR = 2'd0,
    CMD_ADD   = 2'd1,
    CMD_QUERY = 2'd2
  } cmd_t;

  // input beat
  typedef struct packed {
    logic [1:0]        cmd;
    logic [NODE_W-1:0] src_node;
    logic [NODE_W-1:0] dst_node;
    logic              link_enabled;
  } in_t;

  // result beat
  typedef struct packed {
    logic       would_cycle;
    logic [1:0] done_kind;
  } out_t;

  // controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_ADD_RD,
    ST_ADD_WR,
    ST_Q_INIT,
    ST_WALK
  } state_t;

  // controller to datapath commands
  typedef struct packed {
    logic load;
    logic clear_all;
    logic add_rd;
    logic add_wr;
    logic q_init;
    logic q_step;
    logic emit;
  } ctl_t;

  // datapath to controller status
  typedef struct packed {
    logic       same_node;
    logic       hit;
    logic       pending;
    logic       inflight;
  } sts_t;

  // index of the lowest set bit, zero when none is set
  function automatic logic [NODE_W-1:0] lowest_set(input logic [NODES-1:0] vec);
    logic [NODE_W-1:0] idx;
    idx = '0;
    for (int i = NODES - 1; i >= 0; i--) begin
      if (vec[i]) begin
        idx = NODE_W'(i);
      end
    end
    return idx;
  endfunction

endpackage

`default_nettype wire

// File: sv/lcc_ram.sv
// generic single write port ram with registered read
// no dependencies; holds the adjacency rows
`timescale 1ns / 1ps
`default_nettype none

module lcc_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// File: sv/lcc_ctrl.sv
// controller state machine for the link cycle checker
// depends on lcc_pkg; drives the datapath through ctl_t, reads sts_t
`timescale 1ns / 1ps
`default_nettype none

module lcc_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  input  wire logic [1:0]    in_cmd,
  input  wire lcc_pkg::sts_t sts,
  output logic               busy,
  output lcc_pkg::ctl_t      ctl
);
  import lcc_pkg::*;

  state_t state_r, state_nxt;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          case (cmd_t'(in_cmd))
            CMD_CLEAR: state_nxt = ST_CLEAR;
            CMD_ADD:   state_nxt = ST_ADD_RD;
            CMD_QUERY: state_nxt = ST_Q_INIT;
            default:   state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_CLEAR:  state_nxt = ST_IDLE;
      ST_ADD_RD: state_nxt = ST_ADD_WR;
      ST_ADD_WR: state_nxt = ST_IDLE;
      ST_Q_INIT: state_nxt = sts.same_node ? ST_IDLE : ST_WALK;
      ST_WALK: begin
        if (sts.hit || (!sts.pending && !sts.inflight)) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    ctl  = '0;
    busy = 1'b1;
    case (state_r)
      ST_IDLE: begin
        busy     = 1'b0;
        ctl.load = start;
      end
      ST_CLEAR: begin
        ctl.clear_all = 1'b1;
        ctl.emit      = 1'b1;
      end
      ST_ADD_RD: ctl.add_rd = 1'b1;
      ST_ADD_WR: begin
        ctl.add_wr = 1'b1;
        ctl.emit   = 1'b1;
      end
      ST_Q_INIT: begin
        ctl.q_init = 1'b1;
        ctl.emit   = sts.same_node;
      end
      ST_WALK: begin
        ctl.q_step = 1'b1;
        ctl.emit   = sts.hit || (!sts.pending && !sts.inflight);
      end
      default: ctl = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

// File: sv/lcc_dpath.sv
// datapath: adjacency store, row valid bits, reach walk and result register
// depends on lcc_pkg, lcc_ram and the assertion macro header
`timescale 1ns / 1ps
`default_nettype none
`include "link_cycle_checker_unit_macros.svh"

module lcc_dpath (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire lcc_pkg::in_t  in_item,
  input  wire lcc_pkg::ctl_t ctl,
  output lcc_pkg::sts_t      sts,
  output logic               out_strobe,
  output lcc_pkg::out_t      out_item
);
  import lcc_pkg::*;

  in_t               item_r, item_nxt;
  logic [NODES-1:0]  row_valid_r, row_valid_nxt;
  logic [NODES-1:0]  reach_r, reach_nxt;
  logic [NODES-1:0]  done_r, done_nxt;
  logic              inflight_r, inflight_nxt;
  logic [NODE_W-1:0] rd_idx_r;
  logic              out_strobe_r, out_strobe_nxt;
  out_t              out_item_r, out_item_nxt;

  logic [NODES-1:0]  pending;
  logic [NODE_W-1:0] sel;
  logic [NODE_W-1:0] raddr;
  logic [NODES-1:0]  ram_rdata;
  logic [NODES-1:0]  row_in;
  logic [NODES-1:0]  dst_bit;
  logic              ram_we;
  logic              same_node;
  logic              hit;

  // frontier: reached but not yet expanded
  assign pending   = reach_r & ~done_r;
  assign sel       = lowest_set(pending);
  assign same_node = (item_r.src_node == item_r.dst_node);
  assign hit       = reach_r[item_r.src_node];
  assign dst_bit   = {{(NODES-1){1'b0}}, 1'b1} << item_r.dst_node;

  // a row never written since the last clear reads as empty
  assign row_in = row_valid_r[rd_idx_r] ? ram_rdata : '0;
  assign raddr  = ctl.add_rd ? item_r.src_node : sel;
  assign ram_we = ctl.add_wr && item_r.link_enabled;

  lcc_ram #(
    .WIDTH(NODES),
    .DEPTH(NODES)
  ) u_adj_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(item_r.src_node),
    .wdata(row_in | dst_bit),
    .raddr(raddr),
    .rdata(ram_rdata)
  );

  // next values
  always_comb begin
    item_nxt       = ctl.load ? in_item : item_r;
    row_valid_nxt  = row_valid_r;
    reach_nxt      = reach_r;
    done_nxt       = done_r;
    inflight_nxt   = 1'b0;
    out_strobe_nxt = ctl.emit;
    out_item_nxt.would_cycle = (item_r.cmd == CMD_QUERY) && (same_node || hit);
    out_item_nxt.done_kind   = item_r.cmd;

    if (ctl.clear_all) begin
      row_valid_nxt = '0;
    end
    if (ram_we) begin
      row_valid_nxt[item_r.src_node] = 1'b1;
    end
    if (ctl.q_init) begin
      reach_nxt = dst_bit;
      done_nxt  = '0;
    end
    if (ctl.q_step) begin
      // absorb the row read last cycle, issue the next frontier read
      if (inflight_r) begin
        reach_nxt = reach_r | row_in;
      end
      if (|pending) begin
        done_nxt[sel] = 1'b1;
        inflight_nxt  = 1'b1;
      end
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_valid_r  <= '0;
      inflight_r   <= 1'b0;
      out_strobe_r <= 1'b0;
    end else begin
      row_valid_r  <= row_valid_nxt;
      inflight_r   <= inflight_nxt;
      out_strobe_r <= out_strobe_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    item_r     <= item_nxt;
    reach_r    <= reach_nxt;
    done_r     <= done_nxt;
    rd_idx_r   <= raddr;
    out_item_r <= out_item_nxt;
  end

  assign sts.same_node = same_node;
  assign sts.hit       = hit;
  assign sts.pending   = |pending;
  assign sts.inflight  = inflight_r;
  assign out_strobe    = out_strobe_r;
  assign out_item      = out_item_r;

  // checks
  `LCC_ASSERT_IMP(a_inflight_done, clk, rst_n, inflight_r, done_r[rd_idx_r], "read row not marked expanded")
  `LCC_ASSERT_NXT(a_init_reach, clk, rst_n, ctl.q_init, reach_r == dst_bit, "walk did not start at destination")
  `LCC_ASSERT_IMP(a_cycle_kind, clk, rst_n, out_strobe_r && out_item_r.would_cycle, out_item_r.done_kind == CMD_QUERY, "cycle flag on non-query beat")

endmodule

`default_nettype wire

// File: sv/link_cycle_checker_unit.sv
// top level of the link cycle checker: controller plus datapath
// depends on lcc_pkg, lcc_ctrl, lcc_dpath and lcc_ram
`timescale 1ns / 1ps
`default_nettype none

// Keeps a directed graph over 64 nodes and answers whether a new link
// src_node -> dst_node would close a cycle. A command beat is taken when
// start is high and busy is low; exactly one result beat follows for
// clear, add and query (command code 3 is taken and dropped with no result).
// out_strobe marks the result for one cycle and cannot be held off, so the
// receiver must take it then. Clear resets the row valid bits, and add
// does a read of the source row through the registered read port of the
// adjacency memory and then, when link_enabled is set, its write. A query
// of a node against itself is answered in the init state; otherwise the
// walk reads one adjacency row per cycle while frontier nodes remain,
// through the memory's single read port, and a row adds to the reached set
// once its registered read returns. The walk ends early once the source is
// reached. The result strobe appears the cycle after the work ends, when
// busy has already dropped. Clearing uses per-row valid bits, so no sweep
// is needed after reset or on a clear command.
module link_cycle_checker_unit (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         start,
  output logic              busy,
  input  wire lcc_pkg::in_t in_item,
  output logic              out_strobe,
  output lcc_pkg::out_t     out_item
);
  import lcc_pkg::*;

  ctl_t ctl;
  sts_t sts;

  lcc_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .in_cmd(in_item.cmd),
    .sts   (sts),
    .busy  (busy),
    .ctl   (ctl)
  );

  lcc_dpath u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_item   (in_item),
    .ctl       (ctl),
    .sts       (sts),
    .out_strobe(out_strobe),
    .out_item  (out_item)
  );

endmodule

`default_nettype wire
